>>> rtl/shi_pkg.sv
package shi_pkg;

	localparam int MAX_BINS = 64;

	localparam int CEN_W = 40;
	localparam int CNT_W = 48;
	localparam int ENTRY_W = CEN_W + CNT_W;
	localparam int GAP_W = CEN_W + 1;
	localparam int SUM_W = CNT_W + 1;
	localparam int PROD_W = GAP_W + CNT_W;

	localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_READ = 1'b1;

	typedef struct packed {
		logic signed [CEN_W-1:0] centroid;
		logic [CNT_W-1:0] count;
	} bin_t;

endpackage

>>> rtl/streaming_histogram_insert_top.sv
// Channel        | Signals                                          | Direction
// ---------------+--------------------------------------------------+----------
// command        | start, cmd, sample, bin_index (busy is an output)  | in
// result         | done, bin_centroid, bin_count, bins_used,        | out
//                | total_seen, min_seen, max_seen, merge_done       |
// configuration  | bins_in_use_wr_en, bins_in_use_wr_data           | in
//
// A transaction is taken when start is high and busy is low; busy stays high until
// the result strobe. A read past the occupied bins raises done at the accepting
// edge; any other read raises it after the WAIT and RD_USE states. An add runs
// a binary search, moves each bin above the insertion point up one place, and
// with a merge scans the gaps bin by bin, runs 41 multiply and 89 divide steps
// and compacts the bins above the merged pair; each memory read waits in WAIT.
// Reset (arst_n low) empties the histogram; the bin memory is not cleared.
// The result is shown for one cycle on done and cannot be stalled.
module streaming_histogram_insert_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cmd,
	input  logic signed [31:0] sample,
	input  logic [5:0]         bin_index,
	input  logic               bins_in_use_wr_en,
	input  logic [6:0]         bins_in_use_wr_data,
	output logic               done,
	output logic signed [39:0] bin_centroid,
	output logic [47:0]        bin_count,
	output logic [6:0]         bins_used,
	output logic [47:0]        total_seen,
	output logic signed [31:0] min_seen,
	output logic signed [31:0] max_seen,
	output logic               merge_done
);

	// The memory holds one extra entry for the bin that exists briefly before a merge.
	localparam int DEPTH = shi_pkg::MAX_BINS + 1;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(shi_pkg::MAX_BINS + 2);

	typedef enum logic [4:0] {
		IDLE, WAIT, RD_USE, SRCH, SCMP, HIT, INS_LOOP, INS_WR, CHK,
		SC_FIRST, SC_LOOP, SC_CMP, MRD, MRD1, MRD2, MUL, DIV, MWR, MSH, MSH_WR
	} state_t;

	state_t state_q, ret_q;

	logic [6:0] limit_q;
	logic [CW-1:0] occ_q, lo_q, hi_q, mid_q, i_q, best_q;
	logic [AW-1:0] raddr_q;
	logic signed [shi_pkg::CEN_W-1:0] key_q, prev_q, c1_q;
	logic [shi_pkg::GAP_W-1:0] gap_q, mq_q, quo_q;
	logic [shi_pkg::CNT_W-1:0] n1_q, n2_q;
	logic [shi_pkg::SUM_W-1:0] den_q, rem_q;
	logic [shi_pkg::PROD_W-1:0] prod_q;
	logic [6:0] step_q;
	logic [47:0] total_q;
	logic signed [31:0] min_q, max_q;
	logic done_q, merge_q;
	logic signed [39:0] cen_out_q;
	logic [47:0] cnt_out_q;

	logic ram_we;
	logic [AW-1:0] ram_waddr;
	shi_pkg::bin_t ram_wdata, ram_rdata;
	logic [CW-1:0] lim;
	logic signed [shi_pkg::CEN_W-1:0] rd_cen;
	logic [shi_pkg::GAP_W-1:0] gap_new;
	logic [shi_pkg::SUM_W-1:0] sum_n;
	logic [shi_pkg::SUM_W:0] rem_sh;
	logic [shi_pkg::CNT_W-1:0] sum_sat, cnt_inc;
	logic [CW-1:0] mid_new;

	shi_ram #(
		.WIDTH(shi_pkg::ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(raddr_q),
		.rdata(ram_rdata)
	);

	// Effective limit, clamped into the legal range.
	always_comb begin
		if (limit_q < 7'd2) begin
			lim = CW'(2);
		end else if (32'(limit_q) > shi_pkg::MAX_BINS) begin
			lim = CW'(shi_pkg::MAX_BINS);
		end else begin
			lim = CW'(limit_q);
		end
	end

	assign rd_cen = ram_rdata.centroid;
	assign gap_new = {rd_cen[shi_pkg::CEN_W-1], rd_cen} - {prev_q[shi_pkg::CEN_W-1], prev_q};
	assign sum_n = {1'b0, n1_q} + {1'b0, n2_q};
	assign sum_sat = sum_n[shi_pkg::CNT_W] ? shi_pkg::CNT_MAX : sum_n[shi_pkg::CNT_W-1:0];
	assign cnt_inc = (ram_rdata.count == shi_pkg::CNT_MAX) ? shi_pkg::CNT_MAX :
		ram_rdata.count + 48'd1;
	assign mid_new = lo_q + ((hi_q - lo_q) >> 1);
	assign rem_sh = {rem_q, prod_q[shi_pkg::PROD_W-1]};

	// Memory writes come straight from the sequencer state so that a later read of
	// the same entry always sees the new value.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = AW'(lo_q);
		ram_wdata = '{centroid: key_q, count: 48'd1};
		unique case (state_q)
			HIT: begin
				if (rd_cen == key_q) begin
					ram_we = 1'b1;
					ram_wdata = '{centroid: key_q, count: cnt_inc};
				end
			end
			INS_LOOP: begin
				ram_we = !(i_q > lo_q);
			end
			INS_WR, MSH_WR: begin
				ram_we = 1'b1;
				ram_waddr = AW'(i_q);
				ram_wdata = ram_rdata;
			end
			MWR: begin
				ram_we = 1'b1;
				ram_waddr = AW'(best_q);
				ram_wdata = '{centroid: c1_q + $signed(quo_q[shi_pkg::CEN_W-1:0]),
					count: sum_sat};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ret_q <= IDLE;
			limit_q <= 7'd64;
			occ_q <= '0;
			total_q <= '0;
			min_q <= 32'sh7FFFFFFF;
			max_q <= 32'sh80000000;
			done_q <= 1'b0;
			merge_q <= 1'b0;
			cen_out_q <= '0;
			cnt_out_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (bins_in_use_wr_en) begin
				limit_q <= bins_in_use_wr_data;
			end
			unique case (state_q)
				IDLE: begin
					if (start) begin
						merge_q <= 1'b0;
						cen_out_q <= '0;
						cnt_out_q <= '0;
						key_q <= $signed({sample, 8'd0});
						if (cmd == shi_pkg::CMD_READ) begin
							if (bin_index < occ_q) begin
								raddr_q <= AW'(bin_index);
								ret_q <= RD_USE;
								state_q <= WAIT;
							end else begin
								done_q <= 1'b1;
							end
						end else begin
							lo_q <= '0;
							hi_q <= occ_q;
							if (sample < min_q) min_q <= sample;
							if (sample > max_q) max_q <= sample;
							if (total_q != shi_pkg::CNT_MAX) total_q <= total_q + 48'd1;
							state_q <= SRCH;
						end
					end
				end
				WAIT: state_q <= ret_q;
				RD_USE: begin
					cen_out_q <= rd_cen;
					cnt_out_q <= ram_rdata.count;
					done_q <= 1'b1;
					state_q <= IDLE;
				end
				SRCH: begin
					state_q <= WAIT;
					if (lo_q < hi_q) begin
						mid_q <= mid_new;
						raddr_q <= AW'(mid_new);
						ret_q <= SCMP;
					end else if (lo_q < occ_q) begin
						raddr_q <= AW'(lo_q);
						ret_q <= HIT;
					end else begin
						i_q <= occ_q;
						state_q <= INS_LOOP;
					end
				end
				SCMP: begin
					if (rd_cen < key_q) lo_q <= mid_q + CW'(1);
					else hi_q <= mid_q;
					state_q <= SRCH;
				end
				HIT: begin
					if (rd_cen == key_q) begin
						done_q <= 1'b1;
						state_q <= IDLE;
					end else begin
						i_q <= occ_q;
						state_q <= INS_LOOP;
					end
				end
				INS_LOOP: begin
					if (i_q > lo_q) begin
						raddr_q <= AW'(i_q - CW'(1));
						ret_q <= INS_WR;
						state_q <= WAIT;
					end else begin
						occ_q <= occ_q + CW'(1);
						state_q <= CHK;
					end
				end
				INS_WR: begin
					i_q <= i_q - CW'(1);
					state_q <= INS_LOOP;
				end
				CHK: begin
					if (occ_q > lim) begin
						raddr_q <= '0;
						ret_q <= SC_FIRST;
						state_q <= WAIT;
					end else begin
						done_q <= 1'b1;
						state_q <= IDLE;
					end
				end
				SC_FIRST: begin
					prev_q <= rd_cen;
					i_q <= CW'(1);
					state_q <= SC_LOOP;
				end
				SC_LOOP: begin
					if (i_q < occ_q) begin
						raddr_q <= AW'(i_q);
						ret_q <= SC_CMP;
						state_q <= WAIT;
					end else begin
						state_q <= MRD;
					end
				end
				SC_CMP: begin
					// Strictly smaller gaps win, so the lowest pair keeps a tie.
					if (i_q == CW'(1) || gap_new < gap_q) begin
						gap_q <= gap_new;
						best_q <= i_q - CW'(1);
					end
					prev_q <= rd_cen;
					i_q <= i_q + CW'(1);
					state_q <= SC_LOOP;
				end
				MRD: begin
					raddr_q <= AW'(best_q);
					ret_q <= MRD1;
					state_q <= WAIT;
				end
				MRD1: begin
					c1_q <= rd_cen;
					n1_q <= ram_rdata.count;
					raddr_q <= AW'(best_q + CW'(1));
					ret_q <= MRD2;
					state_q <= WAIT;
				end
				MRD2: begin
					n2_q <= ram_rdata.count;
					mq_q <= gap_q;
					prod_q <= '0;
					step_q <= 7'(shi_pkg::GAP_W - 1);
					state_q <= MUL;
				end
				MUL: begin
					// Shift-and-add product of gap and right count, MSB first.
					prod_q <= (prod_q << 1) + (mq_q[shi_pkg::GAP_W-1] ?
						shi_pkg::PROD_W'(n2_q) : '0);
					mq_q <= mq_q << 1;
					if (step_q == 7'd0) begin
						den_q <= sum_n;
						rem_q <= '0;
						quo_q <= '0;
						step_q <= 7'(shi_pkg::PROD_W - 1);
						state_q <= DIV;
					end else begin
						step_q <= step_q - 7'd1;
					end
				end
				DIV: begin
					// Restoring division of the product by the summed counts.
					prod_q <= prod_q << 1;
					if (rem_sh >= {1'b0, den_q}) begin
						rem_q <= shi_pkg::SUM_W'(rem_sh - {1'b0, den_q});
						quo_q <= {quo_q[shi_pkg::GAP_W-2:0], 1'b1};
					end else begin
						rem_q <= shi_pkg::SUM_W'(rem_sh);
						quo_q <= {quo_q[shi_pkg::GAP_W-2:0], 1'b0};
					end
					if (step_q == 7'd0) state_q <= MWR;
					else step_q <= step_q - 7'd1;
				end
				MWR: begin
					i_q <= best_q + CW'(1);
					state_q <= MSH;
				end
				MSH: begin
					if ((i_q + CW'(1)) < occ_q) begin
						raddr_q <= AW'(i_q + CW'(1));
						ret_q <= MSH_WR;
						state_q <= WAIT;
					end else begin
						occ_q <= occ_q - CW'(1);
						merge_q <= 1'b1;
						done_q <= 1'b1;
						state_q <= IDLE;
					end
				end
				MSH_WR: begin
					i_q <= i_q + CW'(1);
					state_q <= MSH;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign busy = (state_q != IDLE);
	assign done = done_q;
	assign bin_centroid = cen_out_q;
	assign bin_count = cnt_out_q;
	assign bins_used = 7'(occ_q);
	assign total_seen = total_q;
	assign min_seen = min_q;
	assign max_seen = max_q;
	assign merge_done = merge_q;

endmodule

>>> rtl/shi_ram.sv
module shi_ram #(
	parameter int WIDTH = 88,
	parameter int DEPTH = 65
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
